FILE: rtl/core/vrl_pkg.sv
// Shared types and constants for the valve reclose lockout block.
// No dependencies; used by vrl_coil and valve_reclose_lockout_top.
`default_nettype none

package vrl_pkg;

    localparam int COIL_COUNT  = 5;
    localparam int COIL_IDX_W  = 3;
    localparam int MAP_W       = 8;
    localparam int TIMER_W     = 16;

    localparam logic [TIMER_W-1:0] LOCKOUT_RESET = 16'd250;

    localparam logic       CMD_SET  = 1'b0;
    localparam logic       CMD_TICK = 1'b1;

    localparam logic [1:0] MODE_OPENED  = 2'd0;
    localparam logic [1:0] MODE_CLOSED  = 2'd1;
    localparam logic [1:0] MODE_WAITING = 2'd2;

    typedef struct packed {
        logic                  command;
        logic [COIL_IDX_W-1:0] coil_index;
        logic                  level;
    } in_t;

    typedef struct packed {
        logic             accepted;
        logic [MAP_W-1:0] requested_map;
        logic [MAP_W-1:0] drive_map;
    } out_t;

    // Per-coil update control from the top level.
    typedef struct packed {
        logic               fire;
        logic               tick;
        logic               sel;
        logic               level;
        logic [TIMER_W-1:0] load;
    } coil_ctrl_t;

    // Per-coil state after the current request.
    typedef struct packed {
        logic closed;
        logic waiting;
        logic fail;
    } coil_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/valve_reclose_lockout_top.sv
// Top level of the valve reclose lockout block: request register, coil bank,
// result register. Depends on vrl_pkg and vrl_coil.
//
// Drives a bank of COIL_COUNT valve coils. Each request is either a set of one
// coil (open or close) or a timer tick, and gives exactly one result with the
// request status and the requested and drive maps (coil 0 at bit COIL_COUNT-1,
// upper bits zero). A request is taken into an input register, applied to all
// coils once the output register is free or being emptied, and the result lands
// in that output register. A new request can be accepted in every cycle while
// the result side keeps taking results. The lockout length (cfg_wr_data, reset
// value 250 ticks, zero acts as one) is to be written with cfg_wr_en only while
// no request is in flight; the block itself does not enforce this.
`default_nettype none

module valve_reclose_lockout_top (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire vrl_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output vrl_pkg::out_t      m_data,
    input  wire logic          cfg_wr_en,
    input  wire logic [15:0]   cfg_wr_data
);

    logic [vrl_pkg::TIMER_W-1:0] lockout_reg;
    logic [vrl_pkg::TIMER_W-1:0] load;
    logic                        in_valid_reg;
    vrl_pkg::in_t                in_reg;
    logic                        out_valid_reg;
    vrl_pkg::out_t               out_reg, out_next;
    logic                        fire;

    vrl_pkg::coil_ctrl_t ctrl [vrl_pkg::COIL_COUNT];
    vrl_pkg::coil_stat_t stat [vrl_pkg::COIL_COUNT];

    // apply the held request when the result slot is free or being emptied
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign load    = (lockout_reg == '0) ? vrl_pkg::TIMER_W'(1) : lockout_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lockout_reg <= vrl_pkg::LOCKOUT_RESET;
        end else if (cfg_wr_en) begin
            lockout_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
    end

    for (genvar i = 0; i < vrl_pkg::COIL_COUNT; i++) begin : g_coil
        assign ctrl[i].fire  = fire;
        assign ctrl[i].tick  = (in_reg.command == vrl_pkg::CMD_TICK);
        assign ctrl[i].sel   = (in_reg.command == vrl_pkg::CMD_SET) &&
                               (in_reg.coil_index == vrl_pkg::COIL_IDX_W'(i));
        assign ctrl[i].level = in_reg.level;
        assign ctrl[i].load  = load;

        vrl_coil u_coil (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl[i]),
            .stat    (stat[i])
        );
    end

    always_comb begin
        out_next.accepted      = 1'b1;
        out_next.requested_map = '0;
        out_next.drive_map     = '0;
        for (int i = 0; i < vrl_pkg::COIL_COUNT; i++) begin
            if (stat[i].fail) begin
                out_next.accepted = 1'b0;
            end
            out_next.requested_map[vrl_pkg::COIL_COUNT-1-i] =
                stat[i].closed || stat[i].waiting;
            out_next.drive_map[vrl_pkg::COIL_COUNT-1-i] = stat[i].closed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

FILE: rtl/core/vrl_coil.sv
// One valve coil: mode, lock flag and lockout timer with their update rules.
// Depends on vrl_pkg.
`default_nettype none

module vrl_coil (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire vrl_pkg::coil_ctrl_t ctrl,
    output vrl_pkg::coil_stat_t    stat
);

    logic [1:0]                  mode_reg, mode_next;
    logic                        locked_reg, locked_next;
    logic [vrl_pkg::TIMER_W-1:0] timer_reg, timer_next;
    logic [vrl_pkg::TIMER_W-1:0] timer_dec;

    assign timer_dec = timer_reg - 1'b1;

    always_comb begin
        mode_next   = mode_reg;
        locked_next = locked_reg;
        timer_next  = timer_reg;
        if (ctrl.fire && ctrl.tick) begin
            if (timer_reg != '0) begin
                timer_next = timer_dec;
                if (timer_dec == '0) begin
                    locked_next = 1'b0;
                    // waiting coil closes and relocks on expiry
                    if (mode_reg == vrl_pkg::MODE_WAITING) begin
                        mode_next   = vrl_pkg::MODE_CLOSED;
                        locked_next = 1'b1;
                        timer_next  = ctrl.load;
                    end
                end
            end
        end else if (ctrl.fire && ctrl.sel) begin
            if (!ctrl.level) begin
                mode_next = vrl_pkg::MODE_OPENED;
            end else if (mode_reg != vrl_pkg::MODE_CLOSED &&
                         mode_reg != vrl_pkg::MODE_WAITING) begin
                if (locked_reg) begin
                    mode_next = vrl_pkg::MODE_WAITING;
                end else begin
                    mode_next   = vrl_pkg::MODE_CLOSED;
                    locked_next = 1'b1;
                    timer_next  = ctrl.load;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= vrl_pkg::MODE_OPENED;
            locked_reg <= 1'b0;
            timer_reg  <= '0;
        end else begin
            mode_reg   <= mode_next;
            locked_reg <= locked_next;
            timer_reg  <= timer_next;
        end
    end

    assign stat.closed  = (mode_next == vrl_pkg::MODE_CLOSED);
    assign stat.waiting = (mode_next == vrl_pkg::MODE_WAITING);
    assign stat.fail    = ctrl.fire && !ctrl.tick && ctrl.sel && ctrl.level &&
                          (mode_next != vrl_pkg::MODE_CLOSED);

endmodule

`default_nettype wire
